[rtl/civt_pkg.sv]
// Shared types, constants and the month table for the civil time converter.
// No dependencies; imported by civt_div and civil_time_to_epoch_seconds_usec.
`default_nettype none

package civt_pkg;

  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int TICK_W    = 64;
  localparam int FREQ_W    = 32;
  localparam int EPOCH_W   = 32;
  localparam int USEC_W    = 20;

  // Year offsets run 0..129, so they need eight bits.
  localparam int YOFF_W    = 8;
  localparam int MDAYS_W   = 9;
  localparam int HMS_W     = 17;

  localparam logic [YEAR_W-1:0]  YEAR_BASE      = 12'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_TOP       = 12'd2099;
  localparam logic [FREQ_W-1:0]  FREQ_RESET     = 32'd100;
  localparam logic [FREQ_W-1:0]  FALLBACK_RATE  = 32'd100;
  localparam logic [16:0]        SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0]        SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]         SECS_PER_MIN   = 6'd60;
  localparam logic [USEC_W-1:0]  USEC_PER_SEC   = 20'd1000000;
  localparam logic [8:0]         DAYS_PER_YEAR  = 9'd365;

  // The divider retires one quotient bit per cycle over the full dividend.
  localparam int DIV_STEPS = TICK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                start;
    logic [TICK_W-1:0]   dividend;
    logic [FREQ_W-1:0]   divisor;
  } div_req_t;

  // Days in the months before the given zero-based month; index 12 is a full year.
  function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] midx);
    logic [MDAYS_W-1:0] d;
    unique case (midx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/civt_div.sv]
// Radix-2 restoring divider shared by the modulo and the scaling divide.
// Depends on civt_pkg for widths and the request struct.
`default_nettype none

module civt_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire civt_pkg::div_req_t      req,
  output logic [civt_pkg::TICK_W-1:0]  quotient,
  output logic [civt_pkg::FREQ_W-1:0]  remainder,
  output logic                         done
);
  import civt_pkg::*;

  logic                  run_r,  run_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [TICK_W-1:0]     quo_r,  quo_nxt;
  logic [FREQ_W-1:0]     rem_r,  rem_nxt;
  logic [FREQ_W-1:0]     dvs_r,  dvs_nxt;
  logic                  done_r, done_nxt;

  logic [FREQ_W:0]       trial;
  logic                  ge;

  // The partial remainder stays below the divisor, so the shifted trial needs one extra bit.
  assign trial = {rem_r, quo_r[TICK_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (run_r) begin
      quo_nxt = {quo_r[TICK_W-2:0], ge};
      rem_nxt = ge ? FREQ_W'(trial - {1'b0, dvs_r}) : trial[FREQ_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

`default_nettype wire

[rtl/civil_time_to_epoch_seconds_usec.sv]
// Top level: civil date and tick count to epoch seconds and microseconds.
// Depends on civt_pkg and civt_div.
`default_nettype none

// A reading is taken at a clock edge with start high and busy low; busy then stays high
// until the result appears. The result appears on out_epoch_seconds and out_microseconds
// for one cycle with out_valid high, 133 cycles after the accepting edge, and the receiver
// must take it in that cycle. The time is set by the shared radix-2 divider, which makes
// two 64-step passes: tick_count modulo the tick frequency, then that remainder times
// one million divided by the frequency. The date arithmetic runs alongside the first pass.
// A tick frequency of zero is treated as 100 Hz. cfg_wdata is loaded into the frequency
// register whenever cfg_we is high; write it only while busy is low.
module civil_time_to_epoch_seconds_usec (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [civt_pkg::YEAR_W-1:0]  in_year,
  input  wire logic [civt_pkg::MONTH_W-1:0] in_month,
  input  wire logic [civt_pkg::DAY_W-1:0]   in_day_of_month,
  input  wire logic [civt_pkg::HOUR_W-1:0]  in_hour,
  input  wire logic [civt_pkg::MIN_W-1:0]   in_minute,
  input  wire logic [civt_pkg::SEC_W-1:0]   in_second,
  input  wire logic [civt_pkg::TICK_W-1:0]  in_tick_count,
  output logic                              out_valid,
  output logic [civt_pkg::EPOCH_W-1:0]      out_epoch_seconds,
  output logic [civt_pkg::USEC_W-1:0]       out_microseconds,
  input  wire logic                         cfg_we,
  input  wire logic [civt_pkg::FREQ_W-1:0]  cfg_wdata
);
  import civt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATE,
    S_REM,
    S_SCALE,
    S_QSTART,
    S_QUO
  } state_t;

  state_t               state_r;
  logic [FREQ_W-1:0]    freq_r;

  logic [YEAR_W-1:0]    year_r;
  logic [MONTH_W-1:0]   month_r;
  logic [DAY_W-1:0]     day_r;
  logic [HOUR_W-1:0]    hour_r;
  logic [MIN_W-1:0]     minute_r;
  logic [SEC_W-1:0]     second_r;
  logic [TICK_W-1:0]    ticks_r;
  logic [FREQ_W-1:0]    dvs_r;

  logic [EPOCH_W-1:0]   days_r;
  logic [HMS_W-1:0]     hms_r;
  logic [EPOCH_W-1:0]   secs_r;
  logic [TICK_W-1:0]    prod_r;

  logic                 out_valid_r;
  logic [EPOCH_W-1:0]   out_secs_r;
  logic [USEC_W-1:0]    out_usec_r;

  logic [YEAR_W-1:0]    year_sat;
  logic [YOFF_W-1:0]    yoff;
  logic [MONTH_W-1:0]   midx;
  logic                 leap_add;
  logic [EPOCH_W-1:0]   days_nxt;
  logic [HMS_W-1:0]     hms_nxt;

  div_req_t             div_req;
  logic [TICK_W-1:0]    div_quo;
  logic [FREQ_W-1:0]    div_rem;
  logic                 div_done;

  // Date arithmetic on the captured reading; all small constant multiplies.
  always_comb begin
    if (year_r < YEAR_BASE) begin
      year_sat = YEAR_BASE;
    end else if (year_r > YEAR_TOP) begin
      year_sat = YEAR_TOP;
    end else begin
      year_sat = year_r;
    end
    yoff = YOFF_W'(year_sat - YEAR_BASE);
    if (month_r == '0) begin
      midx = '0;
    end else begin
      midx = month_r - 1'b1;
    end
    leap_add = (month_r > MONTH_W'(2)) && (year_sat[1:0] == 2'b00);
    // Day zero wraps the total down by one, kept modulo 2^32 like the seconds.
    days_nxt = EPOCH_W'(yoff) * EPOCH_W'(DAYS_PER_YEAR)
             + EPOCH_W'((YOFF_W'(yoff) + 1'b1) >> 2)
             + EPOCH_W'(days_before_month(midx))
             + EPOCH_W'(leap_add)
             + EPOCH_W'(day_r) - EPOCH_W'(1);
    hms_nxt = HMS_W'(hour_r) * HMS_W'(SECS_PER_HOUR)
            + HMS_W'(minute_r) * HMS_W'(SECS_PER_MIN)
            + HMS_W'(second_r);
  end

  always_comb begin
    div_req.start    = (state_r == S_DATE) || (state_r == S_QSTART);
    div_req.dividend = (state_r == S_DATE) ? ticks_r : prod_r;
    div_req.divisor  = dvs_r;
  end

  civt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      freq_r      <= FREQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        freq_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DATE;
          end
        end
        S_DATE: begin
          state_r <= S_REM;
        end
        S_REM: begin
          if (div_done) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_QSTART;
        end
        S_QSTART: begin
          state_r <= S_QUO;
        end
        S_QUO: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end

    if (state_r == S_IDLE && start) begin
      year_r   <= in_year;
      month_r  <= in_month;
      day_r    <= in_day_of_month;
      hour_r   <= in_hour;
      minute_r <= in_minute;
      second_r <= in_second;
      ticks_r  <= in_tick_count;
      // With a zero frequency the 100 Hz fallback gives the same result as a 100 Hz divide.
      dvs_r    <= (freq_r == '0) ? FALLBACK_RATE : freq_r;
    end
    if (state_r == S_DATE) begin
      days_r <= days_nxt;
      hms_r  <= hms_nxt;
    end
    if (state_r == S_SCALE) begin
      secs_r <= EPOCH_W'(days_r * EPOCH_W'(SECS_PER_DAY)) + EPOCH_W'(hms_r);
      prod_r <= TICK_W'(div_rem) * TICK_W'(USEC_PER_SEC);
    end
    if (state_r == S_QUO && div_done) begin
      out_secs_r <= secs_r;
      out_usec_r <= div_quo[USEC_W-1:0];
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = out_secs_r;
  assign out_microseconds  = out_usec_r;

endmodule

`default_nettype wire
